// File: design/bcb_pkg.sv
// Package for the bipartite check block: field widths, reset values and
// request codes used by the top level; its sub-units do not import it.
// No dependencies.
package bcb_pkg;

   // Port field widths
   localparam int NODE_W = 6;
   localparam int CNT_W  = 7;

   // Default node capacity and reset value of the node count register
   localparam int DEF_MAX_NODE_COUNT = 64;
   localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

   // Request codes
   localparam logic REQ_ADD_EDGE = 1'b0;
   localparam logic REQ_RUN      = 1'b1;

endpackage

// File: design/bipartite_check_bfs.sv
// Bipartite check by breadth-first two-colouring: top level with sequencer.
// Depends on bcb_pkg, bcb_ram (adjacency rows) and bcb_lowbit (shared
// lowest-bit search unit).
//
// Usage
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. req_type selects add-edge or run. An edge writes both
//   directions into the adjacency matrix in ST_EDGE_S, then ST_EDGE_D (a
//   self-loop skips ST_EDGE_D), with busy high; an edge with an endpoint
//   at or above the node count is dropped with busy staying low.
//   A run colours the graph, restarting the search from every uncoloured
//   node in ascending order. Each expanded node is picked by the lowest-bit
//   unit in ST_SELECT, which issues the read of its adjacency row; ST_ROW
//   then colours its neighbours in one go. A last ST_SELECT finds no more
//   work. Results then leave at one per cycle: set A ascending, then set B,
//   or a single not-bipartite result as soon as a conflict is seen. Busy
//   falls in the cycle the last result appears on the rsp_ ports.
//   Results are registered and shown for exactly one cycle with rsp_strobe;
//   the receiver cannot stall them.
//   Configuration: csr_node_count is written when csr_valid and csr_ready
//   are high; csr_ready is high whenever the block is idle.
//   Reset: synchronous, active high; it empties the matrix (row valid bits),
//   clears colours and sets the node count to 64. The matrix and colours are
//   cleared again at the end of every run.
module bipartite_check_bfs
   import bcb_pkg::*;
#(
   parameter int MAX_NODE_COUNT = DEF_MAX_NODE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [NODE_W-1:0] req_edge_src,
   input  logic [NODE_W-1:0] req_edge_dst,
   // result channel
   output logic              rsp_strobe,
   output logic              rsp_is_bipartite,
   output logic [NODE_W-1:0] rsp_node_index,
   output logic              rsp_side,
   output logic              rsp_last,
   // configuration channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_node_count
);

   localparam int N     = MAX_NODE_COUNT;
   localparam int IDX_W = $clog2(N);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_S,
      ST_EDGE_D,
      ST_SELECT,
      ST_ROW,
      ST_EMIT
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type          state_ff,   state_in;
   logic [CNT_W-1:0]   cnt_ff,     cnt_in;
   logic [N-1:0]       row_vld_ff, row_vld_in;   // adjacency row written
   logic [N-1:0]       colored_ff, colored_in;   // node has a colour
   logic [N-1:0]       color_b_ff, color_b_in;   // node is in set B
   logic [N-1:0]       pending_ff, pending_in;   // coloured, not expanded
   logic [N-1:0]       cur_oh_ff,  cur_oh_in;    // node being expanded
   logic               cur_b_ff,   cur_b_in;
   logic [N-1:0]       em_ff,      em_in;        // nodes left to report
   logic               pass_b_ff,  pass_b_in;
   logic [IDX_W-1:0]   src_ff,     src_in;
   logic [IDX_W-1:0]   dst_ff,     dst_in;
   logic               vld_q_ff,   vld_q_in;     // valid bit of row read
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_bip_ff,    rsp_bip_in;
   logic [NODE_W-1:0]  rsp_idx_ff,    rsp_idx_in;
   logic               rsp_side_ff,   rsp_side_in;
   logic               rsp_last_ff,   rsp_last_in;

   // ---------------------------------------------------------------------
   // Datapath signals
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]   n_act;
   logic [N-1:0]       keep;
   logic [N-1:0]       src_oh, dst_oh;
   logic               src_ok, dst_ok;

   logic [N-1:0]       lb_vec, lb_oh;
   logic [IDX_W-1:0]   lb_idx;
   logic               lb_any;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [N-1:0]       wr_data, rd_data, row;

   logic [N-1:0]       row_k, same, fresh, rest, b_set;
   logic               fin;

   // Clamp the node count to 1 .. MAX_NODE_COUNT
   always_comb begin
      if (cnt_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (cnt_ff > CNT_W'(N)) begin
         n_act = CNT_W'(N);
      end else begin
         n_act = cnt_ff;
      end
   end

   // Masks of active nodes and of the latched edge endpoints
   always_comb begin
      for (int i = 0; i < N; i++) begin
         keep[i]   = (CNT_W'(i) < n_act);
         src_oh[i] = (src_ff == IDX_W'(i));
         dst_oh[i] = (dst_ff == IDX_W'(i));
      end
   end

   assign src_ok = (CNT_W'(req_edge_src) < n_act);
   assign dst_ok = (CNT_W'(req_edge_dst) < n_act);

   // Row that was never written since the last clear reads as zero
   assign row = vld_q_ff ? rd_data : '0;

   bcb_ram #(
      .WIDTH (N),
      .DEPTH (N)
   ) u_adj (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bcb_lowbit #(
      .W (N)
   ) u_lowbit (
      .vec    (lb_vec),
      .onehot (lb_oh),
      .idx    (lb_idx),
      .any    (lb_any)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_vld_in    = row_vld_ff;
      colored_in    = colored_ff;
      color_b_in    = color_b_ff;
      pending_in    = pending_ff;
      cur_oh_in     = cur_oh_ff;
      cur_b_in      = cur_b_ff;
      em_in         = em_ff;
      pass_b_in     = pass_b_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      rsp_strobe_in = 1'b0;
      rsp_bip_in    = rsp_bip_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_side_in   = rsp_side_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = src_ff;
      wr_data       = row;
      rd_addr       = '0;
      lb_vec        = em_ff;
      row_k         = row & keep;
      same          = cur_b_ff ? (colored_ff & color_b_ff) : (colored_ff & ~color_b_ff);
      fresh         = row_k & ~colored_ff;
      rest          = em_ff & ~lb_oh;
      b_set         = colored_ff & color_b_ff;
      fin           = (rest == '0) && (pass_b_ff || (b_set == '0));

      if (csr_valid && csr_ready) begin
         cnt_in = csr_node_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // read the source row speculatively for an edge transaction
            rd_addr = req_edge_src[IDX_W-1:0];
            if (start) begin
               if (req_type == REQ_RUN) begin
                  state_in = ST_SELECT;
               end else if (src_ok && dst_ok) begin
                  src_in   = req_edge_src[IDX_W-1:0];
                  dst_in   = req_edge_dst[IDX_W-1:0];
                  state_in = ST_EDGE_S;
               end
            end
         end
         ST_EDGE_S: begin
            // set bit dst in row src, fetch row dst
            wr_en      = 1'b1;
            wr_addr    = src_ff;
            wr_data    = row | dst_oh;
            row_vld_in = row_vld_ff | src_oh;
            rd_addr    = dst_ff;
            state_in   = (src_ff == dst_ff) ? ST_IDLE : ST_EDGE_D;
         end
         ST_EDGE_D: begin
            wr_en      = 1'b1;
            wr_addr    = dst_ff;
            wr_data    = row | src_oh;
            row_vld_in = row_vld_ff | dst_oh;
            state_in   = ST_IDLE;
         end
         ST_SELECT: begin
            // expand pending nodes first; otherwise root a new component
            lb_vec  = (pending_ff != '0) ? pending_ff : (keep & ~colored_ff);
            rd_addr = lb_idx;
            if (lb_any) begin
               cur_oh_in  = lb_oh;
               cur_b_in   = |(lb_oh & color_b_ff);
               pending_in = pending_ff & ~lb_oh;
               colored_in = colored_ff | lb_oh;
               state_in   = ST_ROW;
            end else begin
               em_in     = colored_ff & ~color_b_ff;
               pass_b_in = 1'b0;
               state_in  = ST_EMIT;
            end
         end
         ST_ROW: begin
            if ((row_k & same) != '0) begin
               // neighbour with the same colour: report and drop the run
               rsp_strobe_in = 1'b1;
               rsp_bip_in    = 1'b0;
               rsp_idx_in    = '0;
               rsp_side_in   = 1'b0;
               rsp_last_in   = 1'b1;
               row_vld_in    = '0;
               colored_in    = '0;
               color_b_in    = '0;
               pending_in    = '0;
               state_in      = ST_IDLE;
            end else begin
               colored_in = colored_ff | fresh;
               color_b_in = cur_b_ff ? color_b_ff : (color_b_ff | fresh);
               pending_in = pending_ff | fresh;
               state_in   = ST_SELECT;
            end
         end
         ST_EMIT: begin
            lb_vec        = em_ff;
            rsp_strobe_in = 1'b1;
            rsp_bip_in    = 1'b1;
            rsp_idx_in    = NODE_W'(lb_idx);
            rsp_side_in   = pass_b_ff;
            rsp_last_in   = fin;
            if (fin) begin
               row_vld_in = '0;
               colored_in = '0;
               color_b_in = '0;
               pending_in = '0;
               state_in   = ST_IDLE;
            end else if (rest == '0) begin
               em_in     = b_set;
               pass_b_in = 1'b1;
            end else begin
               em_in = rest;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign vld_q_in = row_vld_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= CNT_RESET;
         row_vld_ff    <= '0;
         colored_ff    <= '0;
         color_b_ff    <= '0;
         pending_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         row_vld_ff    <= row_vld_in;
         colored_ff    <= colored_in;
         color_b_ff    <= color_b_in;
         pending_ff    <= pending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cur_oh_ff   <= cur_oh_in;
      cur_b_ff    <= cur_b_in;
      em_ff       <= em_in;
      pass_b_ff   <= pass_b_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      vld_q_ff    <= vld_q_in;
      rsp_bip_ff  <= rsp_bip_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_side_ff <= rsp_side_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_is_bipartite = rsp_bip_ff;
   assign rsp_node_index   = rsp_idx_ff;
   assign rsp_side         = rsp_side_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_ROW || $past(state_ff) == ST_EMIT))
      else $error("result strobe without a run in progress");

   a_b_colored: assert property (@(posedge clock) disable iff (reset)
      (color_b_ff & ~colored_ff) == '0)
      else $error("set B node without a colour");

   a_pend_colored: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~colored_ff) == '0)
      else $error("pending node without a colour");

   a_conflict_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_bipartite) |-> rsp_last)
      else $error("not-bipartite result is not the final one");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_RUN) |=> busy)
      else $error("run transaction did not raise busy");

endmodule

// File: design/bcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the adjacency rows.
module bcb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bcb_lowbit.sv
// Lowest-set-bit finder: isolates the lowest set bit of a vector with one
// add and encodes its position. Shared by the search and the result scan.
// Depends on nothing.
module bcb_lowbit #(
   parameter int W = 64
) (
   input  logic [W-1:0]         vec,
   output logic [W-1:0]         onehot,
   output logic [$clog2(W)-1:0] idx,
   output logic                 any
);

   localparam int IW = $clog2(W);

   assign onehot = vec & (~vec + W'(1));
   assign any    = |vec;

   // encode the isolated bit
   always_comb begin
      idx = '0;
      for (int i = 0; i < W; i++) begin
         if (onehot[i]) begin
            idx = idx | IW'(i);
         end
      end
   end

endmodule
